### design/heap_sort_engine_assert.svh
// Assertion macros used by the checker file.
// Both expect clk and rst_n in scope.
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

// same-cycle implication
`define HSE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/hse_pkg.sv
package hse_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BUILD_NEXT,
        ST_GET_NODE,
        ST_SIFT,
        ST_CMP,
        ST_MOVE,
        ST_EXTRACT,
        ST_SWAP,
        ST_EMIT_RD,
        ST_EMIT_LD
    } seq_state_t;

    // comparator operand select
    typedef enum logic {
        CMP_KIDS,   // right child > left child
        CMP_HOLE    // larger child > value being sifted
    } cmp_sel_t;

    // RAM write data select
    typedef enum logic [1:0] {
        WR_ITEM,
        WR_HOLE,
        WR_CHILD,
        WR_ROOT
    } wr_sel_t;

    typedef struct packed {
        cmp_sel_t cmp_sel;
        logic     v_ld;
        logic     m_ld;
        logic     has_b;
        wr_sel_t  wr_sel;
    } dp_ctrl_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] ra_addr;
        logic [IDX_W-1:0] rb_addr;
    } ram_req_t;

    typedef struct packed {
        logic ld;
        logic last;
        logic ovf;
    } emit_t;

endpackage

### design/hse_ram.sv
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] ra_data_reg;
    logic [WIDTH-1:0] rb_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        ra_data_reg <= mem_reg[ra_addr];
        rb_data_reg <= mem_reg[rb_addr];
    end

    assign ra_data = ra_data_reg;
    assign rb_data = rb_data_reg;

endmodule

### design/hse_dp.sv
module hse_dp
    import hse_pkg::*;
(
    input  logic                     clk,
    input  dp_ctrl_t                 ctrl,
    input  logic signed [DATA_W-1:0] value,
    input  logic [DATA_W-1:0]        ra_data,
    input  logic [DATA_W-1:0]        rb_data,
    output logic                     gt,
    output logic [DATA_W-1:0]        wdata
);

    logic [DATA_W-1:0] v_reg;   // value being sifted (the hole)
    logic [DATA_W-1:0] v_next;
    logic [DATA_W-1:0] m_reg;   // larger child
    logic [DATA_W-1:0] m_next;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;

    // the one shared signed comparator
    always_comb
    begin
        unique case (ctrl.cmp_sel)
            CMP_KIDS:
            begin
                lhs = rb_data;
                rhs = ra_data;
            end
            CMP_HOLE:
            begin
                lhs = m_reg;
                rhs = v_reg;
            end
            default:
            begin
                lhs = m_reg;
                rhs = v_reg;
            end
        endcase
    end

    assign gt = $signed(lhs) > $signed(rhs);

    always_comb
    begin
        v_next = ctrl.v_ld ? ra_data : v_reg;
        m_next = m_reg;
        if (ctrl.m_ld)
        begin
            m_next = (ctrl.has_b && gt) ? rb_data : ra_data;
        end
    end

    always_comb
    begin
        unique case (ctrl.wr_sel)
            WR_ITEM:  wdata = value;
            WR_HOLE:  wdata = v_reg;
            WR_CHILD: wdata = m_reg;
            WR_ROOT:  wdata = rb_data;
            default:  wdata = v_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        m_reg <= m_next;
    end

endmodule

### design/hse_seq.sv
module hse_seq
    import hse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     last,
    output logic     item_stall,
    input  logic     gt,
    input  logic     out_busy,
    output ram_req_t ram_req,
    output dp_ctrl_t dp_ctrl,
    output emit_t    emit
);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [IDX_W-1:0] top_reg;
    logic [IDX_W-1:0] top_next;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] node_reg;
    logic [IDX_W-1:0] node_next;
    logic [IDX_W-1:0] c_reg;
    logic [IDX_W-1:0] c_next;
    logic             extract_reg;
    logic             extract_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;

    logic             item_xfer;
    logic             has_room;
    logic [CNT_W-1:0] count_fin;
    logic [IDX_W-1:0] top_init;
    logic [IDX_W:0]   child;
    logic             child_past;
    logic             has_b;
    logic [IDX_W-1:0] kid_a;
    logic [IDX_W-1:0] kid_b;
    logic             emit_last;

    assign item_xfer  = item_valid && (state_reg == ST_LOAD);
    assign has_room   = count_reg < CNT_W'(CAPACITY);
    assign count_fin  = has_room ? count_reg + CNT_W'(1) : count_reg;
    assign top_init   = IDX_W'(count_fin - CNT_W'(1));
    assign child      = {node_reg, 1'b1};
    assign child_past = child > {1'b0, top_reg};
    assign has_b      = child < {1'b0, top_reg};
    assign kid_a      = child[IDX_W-1:0];
    assign kid_b      = kid_a + IDX_W'(1);
    assign emit_last  = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_xfer && last)
                begin
                    state_next = ST_BUILD_NEXT;
                end
            end
            ST_BUILD_NEXT:
            begin
                state_next = (i_reg == '0) ? ST_EXTRACT : ST_GET_NODE;
            end
            ST_GET_NODE:
            begin
                state_next = ST_SIFT;
            end
            ST_SIFT:
            begin
                if (child_past)
                begin
                    state_next = extract_reg ? ST_EXTRACT : ST_BUILD_NEXT;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                if (gt)
                begin
                    state_next = ST_SIFT;
                end
                else
                begin
                    state_next = extract_reg ? ST_EXTRACT : ST_BUILD_NEXT;
                end
            end
            ST_EXTRACT:
            begin
                state_next = (top_reg == '0) ? ST_EMIT_RD : ST_SWAP;
            end
            ST_SWAP:
            begin
                state_next = ST_SIFT;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (!out_busy)
                begin
                    state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs and datapath registers
    always_comb
    begin
        item_stall      = 1'b1;
        ram_req.we      = 1'b0;
        ram_req.waddr   = node_reg;
        ram_req.ra_addr = kid_a;
        ram_req.rb_addr = kid_b;
        dp_ctrl.cmp_sel = CMP_KIDS;
        dp_ctrl.v_ld    = 1'b0;
        dp_ctrl.m_ld    = 1'b0;
        dp_ctrl.has_b   = 1'b0;
        dp_ctrl.wr_sel  = WR_HOLE;
        emit.ld         = 1'b0;
        emit.last       = emit_last;
        emit.ovf        = ovf_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        top_next        = top_reg;
        i_next          = i_reg;
        node_next       = node_reg;
        c_next          = c_reg;
        extract_next    = extract_reg;
        k_next          = k_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                item_stall     = 1'b0;
                ram_req.waddr  = count_reg[IDX_W-1:0];
                dp_ctrl.wr_sel = WR_ITEM;
                ram_req.we     = item_xfer && has_room;
                if (item_xfer)
                begin
                    count_next = count_fin;
                    ovf_next   = ovf_reg || !has_room;
                    if (last)
                    begin
                        top_next     = top_init;
                        i_next       = (top_init >> 1) + IDX_W'(1);
                        extract_next = 1'b0;
                    end
                end
            end
            ST_BUILD_NEXT:
            begin
                ram_req.ra_addr = i_reg - IDX_W'(1);
                if (i_reg != '0)
                begin
                    i_next    = i_reg - IDX_W'(1);
                    node_next = i_reg - IDX_W'(1);
                end
                else
                begin
                    extract_next = 1'b1;
                end
            end
            ST_GET_NODE:
            begin
                dp_ctrl.v_ld = 1'b1;
            end
            ST_SIFT:
            begin
                // leaf reached: drop the value into the hole
                if (child_past)
                begin
                    ram_req.we = 1'b1;
                end
            end
            ST_CMP:
            begin
                dp_ctrl.cmp_sel = CMP_KIDS;
                dp_ctrl.m_ld    = 1'b1;
                dp_ctrl.has_b   = has_b;
                c_next          = (has_b && gt) ? kid_b : kid_a;
            end
            ST_MOVE:
            begin
                dp_ctrl.cmp_sel = CMP_HOLE;
                ram_req.we      = 1'b1;
                if (gt)
                begin
                    dp_ctrl.wr_sel = WR_CHILD;
                    node_next      = c_reg;
                end
            end
            ST_EXTRACT:
            begin
                ram_req.ra_addr = top_reg;
                ram_req.rb_addr = '0;
            end
            ST_SWAP:
            begin
                // root goes to the end, old end value becomes the hole at root
                dp_ctrl.v_ld   = 1'b1;
                dp_ctrl.wr_sel = WR_ROOT;
                ram_req.we     = 1'b1;
                ram_req.waddr  = top_reg;
                top_next       = top_reg - IDX_W'(1);
                node_next      = '0;
            end
            ST_EMIT_RD:
            begin
                ram_req.ra_addr = k_reg;
            end
            ST_EMIT_LD:
            begin
                ram_req.ra_addr = k_reg;
                if (!out_busy)
                begin
                    emit.ld = 1'b1;
                    k_next  = k_reg + IDX_W'(1);
                    if (emit_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        k_next     = '0;
                    end
                end
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            top_reg     <= '0;
            i_reg       <= '0;
            node_reg    <= '0;
            c_reg       <= '0;
            extract_reg <= 1'b0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            top_reg     <= top_next;
            i_reg       <= i_next;
            node_reg    <= node_next;
            c_reg       <= c_next;
            extract_reg <= extract_next;
            k_reg       <= k_next;
        end
    end

endmodule

### design/heap_sort_engine.sv
// Channel   Signals                                  Transfer when
// -------   --------------------------------------   ----------------------------
// item      item_valid, item_stall, value, last      item_valid && !item_stall
// result    result_valid, result_stall,              result_valid && !result_stall
//           sorted_value, last_out, overflow
//
// Loading accepts one item per cycle; the block stays ready until the item with last set.
// Then it sorts in place: a sift step reads both children, picks the larger, then
// compares it with the hole and writes. The sort is paced by the one comparator and the
// two-read-port store. Results then leave one at a time, each read from the store and
// then loaded into the output register.
// item_stall stays high from the last item until the final result is in the output
// register; result_stall only holds that register and pauses the emit sequence.
// Reset (rst_n, asynchronous) clears the sequencer, counts and result_valid; the store
// holds no reset value and its contents are only used where the current batch wrote them.
module heap_sort_engine
    import hse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     overflow
);

    ram_req_t          ram_req;
    dp_ctrl_t          dp_ctrl;
    emit_t             emit;
    logic              gt;
    logic              out_busy;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] ra_data;
    logic [DATA_W-1:0] rb_data;

    // output register
    logic              result_valid_reg;
    logic              result_valid_next;
    logic [DATA_W-1:0] sorted_value_reg;
    logic              last_out_reg;
    logic              overflow_reg;

    // sequencer: load, heap build, extraction, emit
    hse_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .last       (last),
        .item_stall (item_stall),
        .gt         (gt),
        .out_busy   (out_busy),
        .ram_req    (ram_req),
        .dp_ctrl    (dp_ctrl),
        .emit       (emit)
    );

    // hole/child value registers around the shared comparator
    hse_dp u_dp (
        .clk     (clk),
        .ctrl    (dp_ctrl),
        .value   (value),
        .ra_data (ra_data),
        .rb_data (rb_data),
        .gt      (gt),
        .wdata   (wdata)
    );

    // element store: one write, two registered reads per cycle
    hse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (wdata),
        .ra_addr (ram_req.ra_addr),
        .ra_data (ra_data),
        .rb_addr (ram_req.rb_addr),
        .rb_data (rb_data)
    );

    // a held result blocks the next emit
    assign out_busy = result_valid_reg && result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (emit.ld)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.ld)
        begin
            sorted_value_reg <= ra_data;
            last_out_reg     <= emit.last;
            overflow_reg     <= emit.ovf;
        end
    end

    assign result_valid = result_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign last_out     = last_out_reg;
    assign overflow     = overflow_reg;

endmodule

### design/heap_sort_engine_checker.sv
`include "heap_sort_engine_assert.svh"

module heap_sort_engine_checker
    import hse_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_stall,
    input logic                     last,
    input logic                     result_valid,
    input logic                     result_stall,
    input logic signed [DATA_W-1:0] sorted_value,
    input logic                     last_out,
    input logic                     overflow
);

    // a stalled result stays put
    `HSE_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(sorted_value) && $stable(last_out) && $stable(overflow), "result changed while stalled")

    // the final item of a batch starts the sort, so the input closes
    `HSE_ASSERT_NXT(a_busy_after_last, item_valid && !item_stall && last, item_stall, "input open right after final item")

    // a non-final item leaves the block ready for the next one
    `HSE_ASSERT_NXT(a_ready_in_batch, item_valid && !item_stall && !last, !item_stall, "input closed inside a batch")

    // while a batch is still being emitted no new item is taken
    `HSE_ASSERT_IMP(a_no_load_midbatch, result_valid && !last_out, item_stall, "input open during emit")

endmodule

bind heap_sort_engine heap_sort_engine_checker u_checker (.*);
